@@ hdl/pmt_pkg.sv @@
// shared types and constants for the program map section parser
package pmt_pkg;

    localparam logic [7:0] PMT_TABLE_ID = 8'h02;
    localparam int MAX_ENTRIES = 16;
    localparam int ENTRY_CNT_W = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_TDATA_W = 104;

    typedef enum logic [2:0] {
        KIND_HEADER    = 3'd0,
        KIND_ENTRY     = 3'd1,
        KIND_DONE      = 3'd2,
        KIND_BAD_TABLE = 3'd3,
        KIND_FULL      = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_WAIT   = 2'd2,
        PH_ENTRY  = 2'd3
    } t_phase;

    typedef struct packed {
        t_kind                    kind;
        logic [15:0]              prog_num;
        logic [4:0]               version;
        logic                     current_next;
        logic [7:0]               section_index;
        logic [7:0]               last_section_index;
        logic [12:0]              clock_ref_pid;
        logic [11:0]              program_info_len;
        logic [7:0]               es_type;
        logic [12:0]              es_pid;
        logic [11:0]              es_info_len;
        logic [ENTRY_CNT_W-1:0]   entry_count;
    } t_result;

    // up to two results per byte, the second only with the first
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        t_result rec0;
        t_result rec1;
    } t_push;

    typedef struct packed {
        logic    valid;
        t_result rec;
    } t_head;

endpackage

@@ hdl/pmt_section_parser.sv @@
// top level of the program map section parser
// path: a result passes through the result queue and then the output register to the master side
// a second result from the same byte follows the first through the queue
// throughput: one section byte per cycle, held off only while the result queue
// has fewer than two free slots (output stalled)
// reset: synchronous, active low; clears parser phase, queue pointers and output valid
module pmt_section_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // section byte input
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] section_byte
    input  logic [0:0]                      s_axis_tuser,   // [0] section_start
    // parse results
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] prog_num, [20:16] version, [21] current_next,
    // [29:22] section_index, [37:30] last_section_index, [50:38] clock_ref_pid,
    // [62:51] program_info_len, [70:63] es_type, [83:71] es_pid,
    // [95:84] es_info_len, [100:96] entry_count, [103:101] zero
    output logic [pmt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [2:0]                      m_axis_tuser    // [2:0] kind
);

    pmt_pkg::t_push push;
    pmt_pkg::t_head head;
    logic           room;
    logic           pop;
    logic           accept;

    // a byte transfer happens whenever the queue can take a pair of results
    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    // front: classifies each byte and walks header and stream entries
    pmt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_start  (s_axis_tuser[0]),
        .o_push   (push)
    );

    // queue decouples the byte side from output backpressure
    pmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_room  (room),
        .o_head  (head)
    );

    // back: registered output with one result per transfer
    pmt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

endmodule

@@ hdl/pmt_front.sv @@
// byte classifier and section walker, pushes result records into the queue
module pmt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_start,
    output pmt_pkg::t_push   o_push
);

    pmt_pkg::t_phase r_phase, n_phase;
    logic [12:0] r_pos, n_pos;
    logic [11:0] r_sec_len, n_sec_len;
    logic [12:0] r_ent_off, n_ent_off;
    logic [2:0]  r_ent_idx, n_ent_idx;
    logic [pmt_pkg::ENTRY_CNT_W-1:0] r_entries, n_entries;
    logic [7:0]  r_held, n_held;
    logic [15:0] r_prog, n_prog;
    logic [4:0]  r_ver, n_ver;
    logic        r_cn, n_cn;
    logic [7:0]  r_sec, n_sec;
    logic [7:0]  r_last, n_last;
    logic [12:0] r_pcr, n_pcr;
    logic [11:0] r_pil, n_pil;
    logic [7:0]  r_type, n_type;
    logic [12:0] r_pid, n_pid;

    logic [11:0] low_len;
    logic [13:0] next_off;
    logic [13:0] consumed_ent;
    logic [13:0] consumed_hdr;
    logic [2:0]  idx;
    logic        ent_step;
    logic        v0, v1, with_entry;
    pmt_pkg::t_kind kind0, kind1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pmt_pkg::PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_sec_len <= n_sec_len;
        r_ent_off <= n_ent_off;
        r_ent_idx <= n_ent_idx;
        r_entries <= n_entries;
        r_held    <= n_held;
        r_prog    <= n_prog;
        r_ver     <= n_ver;
        r_cn      <= n_cn;
        r_sec     <= n_sec;
        r_last    <= n_last;
        r_pcr     <= n_pcr;
        r_pil     <= n_pil;
        r_type    <= n_type;
        r_pid     <= n_pid;
    end

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_sec_len = r_sec_len;
        n_ent_off = r_ent_off;
        n_ent_idx = r_ent_idx;
        n_entries = r_entries;
        n_held    = r_held;
        n_prog    = r_prog;
        n_ver     = r_ver;
        n_cn      = r_cn;
        n_sec     = r_sec;
        n_last    = r_last;
        n_pcr     = r_pcr;
        n_pil     = r_pil;
        n_type    = r_type;
        n_pid     = r_pid;
        v0         = 1'b0;
        v1         = 1'b0;
        with_entry = 1'b0;
        kind0      = pmt_pkg::KIND_HEADER;
        kind1      = pmt_pkg::KIND_DONE;

        // 12-bit length fields share this shape
        low_len      = {r_held[3:0], i_byte};
        next_off     = {1'b0, r_ent_off} + 14'd5 + {2'b00, low_len};
        consumed_ent = next_off + 14'd1;
        consumed_hdr = 14'd13 + {2'b00, low_len};
        idx          = (r_phase == pmt_pkg::PH_ENTRY) ? r_ent_idx : 3'd0;
        ent_step     = 1'b0;

        if (i_accept) begin
            if (i_start) begin
                n_pos     = '0;
                n_sec_len = '0;
                n_ent_off = '0;
                n_ent_idx = '0;
                n_entries = '0;
                n_held    = '0;
                n_prog    = '0;
                n_ver     = '0;
                n_cn      = 1'b0;
                n_sec     = '0;
                n_last    = '0;
                n_pcr     = '0;
                n_pil     = '0;
                n_type    = '0;
                n_pid     = '0;
                if (i_byte == pmt_pkg::PMT_TABLE_ID) begin
                    n_phase = pmt_pkg::PH_HEADER;
                end else begin
                    n_phase = pmt_pkg::PH_IDLE;
                    v0      = 1'b1;
                    kind0   = pmt_pkg::KIND_BAD_TABLE;
                end
            end else if (r_phase != pmt_pkg::PH_IDLE) begin
                n_pos = r_pos + 13'd1;
                if (r_phase == pmt_pkg::PH_HEADER) begin
                    case (n_pos[3:0])
                        4'd1, 4'd3, 4'd8, 4'd10: n_held = i_byte;
                        4'd2: n_sec_len = low_len;
                        4'd4: n_prog = {r_held, i_byte};
                        4'd5: begin
                            n_ver = i_byte[5:1];
                            n_cn  = i_byte[0];
                        end
                        4'd6: n_sec = i_byte;
                        4'd7: n_last = i_byte;
                        4'd9: n_pcr = {r_held[4:0], i_byte};
                        default: begin
                            // last header byte: emit header, test for an empty entry loop
                            n_pil = low_len;
                            v0    = 1'b1;
                            kind0 = pmt_pkg::KIND_HEADER;
                            if (consumed_hdr >= {2'b00, r_sec_len}) begin
                                n_phase = pmt_pkg::PH_IDLE;
                                v1      = 1'b1;
                                kind1   = pmt_pkg::KIND_DONE;
                            end else begin
                                n_ent_off = 13'd12 + {1'b0, low_len};
                                n_phase   = pmt_pkg::PH_WAIT;
                            end
                        end
                    endcase
                end else begin
                    ent_step = (r_phase == pmt_pkg::PH_ENTRY) || (n_pos == r_ent_off);
                    if (ent_step) begin
                        n_phase   = pmt_pkg::PH_ENTRY;
                        n_ent_idx = idx + 3'd1;
                        case (idx)
                            3'd0: n_type = i_byte;
                            3'd1, 3'd3: n_held = i_byte;
                            3'd2: n_pid = {r_held[4:0], i_byte};
                            default: begin
                                n_entries  = r_entries + pmt_pkg::ENTRY_CNT_W'(1);
                                v0         = 1'b1;
                                kind0      = pmt_pkg::KIND_ENTRY;
                                with_entry = 1'b1;
                                n_ent_idx  = '0;
                                if (consumed_ent >= {2'b00, r_sec_len}) begin
                                    n_phase = pmt_pkg::PH_IDLE;
                                    v1      = 1'b1;
                                    kind1   = pmt_pkg::KIND_DONE;
                                end else if (n_entries >=
                                        pmt_pkg::ENTRY_CNT_W'(pmt_pkg::MAX_ENTRIES)) begin
                                    n_phase = pmt_pkg::PH_IDLE;
                                    v1      = 1'b1;
                                    kind1   = pmt_pkg::KIND_FULL;
                                end else begin
                                    n_ent_off = next_off[12:0];
                                    n_phase   = pmt_pkg::PH_WAIT;
                                end
                            end
                        endcase
                    end
                end
            end
        end

        o_push.valid0 = v0;
        o_push.valid1 = v1;
        o_push.rec0.kind               = kind0;
        o_push.rec0.prog_num           = n_prog;
        o_push.rec0.version            = n_ver;
        o_push.rec0.current_next       = n_cn;
        o_push.rec0.section_index      = n_sec;
        o_push.rec0.last_section_index = n_last;
        o_push.rec0.clock_ref_pid      = n_pcr;
        o_push.rec0.program_info_len   = n_pil;
        o_push.rec0.es_type            = with_entry ? n_type : 8'd0;
        o_push.rec0.es_pid             = with_entry ? n_pid : 13'd0;
        o_push.rec0.es_info_len        = with_entry ? low_len : 12'd0;
        o_push.rec0.entry_count        = n_entries;
        o_push.rec1                    = o_push.rec0;
        o_push.rec1.kind               = kind1;
        o_push.rec1.es_type            = 8'd0;
        o_push.rec1.es_pid             = 13'd0;
        o_push.rec1.es_info_len        = 12'd0;
    end

endmodule

@@ hdl/pmt_queue.sv @@
// short result queue, takes up to two records per cycle and gives one
module pmt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pmt_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_room,
    output pmt_pkg::t_head   o_head
);

    pmt_pkg::t_result r_mem [pmt_pkg::QUEUE_DEPTH];
    logic [pmt_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [pmt_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [pmt_pkg::QCNT_W-1:0] r_count, n_count;
    logic [pmt_pkg::QCNT_W-1:0] n_pushed;
    logic                       pop_ok;

    always_comb begin
        pop_ok   = i_pop && (r_count != '0);
        n_pushed = pmt_pkg::QCNT_W'(i_push.valid0) + pmt_pkg::QCNT_W'(i_push.valid1);
        n_wr_ptr = r_wr_ptr + pmt_pkg::QPTR_W'(n_pushed);
        n_rd_ptr = r_rd_ptr + pmt_pkg::QPTR_W'(pop_ok);
        n_count  = r_count + n_pushed - pmt_pkg::QCNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid0) begin
            r_mem[r_wr_ptr] <= i_push.rec0;
        end
        if (i_push.valid1) begin
            r_mem[r_wr_ptr + pmt_pkg::QPTR_W'(1)] <= i_push.rec1;
        end
    end

    // room for a full pair regardless of this cycle's pop
    assign o_room       = r_count <= pmt_pkg::QCNT_W'(pmt_pkg::QUEUE_DEPTH - 2);
    assign o_head.valid = r_count != '0;
    assign o_head.rec   = r_mem[r_rd_ptr];

endmodule

@@ hdl/pmt_back.sv @@
// output register stage, drains the queue onto the master stream
module pmt_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pmt_pkg::t_head                  i_head,
    output logic                            o_pop,
    input  logic                            i_tready,
    output logic                            o_tvalid,
    output logic [pmt_pkg::OUT_TDATA_W-1:0] o_tdata,
    output logic [2:0]                      o_tuser
);

    logic             r_valid, n_valid;
    pmt_pkg::t_result r_rec;

    always_comb begin
        o_pop   = i_head.valid && (!r_valid || i_tready);
        n_valid = o_pop || (r_valid && !i_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_head.rec;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tuser  = r_rec.kind;
    assign o_tdata  = {3'b000, r_rec.entry_count, r_rec.es_info_len, r_rec.es_pid,
                       r_rec.es_type, r_rec.program_info_len, r_rec.clock_ref_pid,
                       r_rec.last_section_index, r_rec.section_index, r_rec.current_next,
                       r_rec.version, r_rec.prog_num};

endmodule

@@ verif/pmt_section_parser_test.sv @@
// testbench for pmt_section_parser: random program map sections checked against a built-in parser model
module pmt_section_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    // one section byte waiting to be offered, calm marks bytes sent with no idle gap
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       calm;
    } t_sec_byte;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;   // [7:0] section_byte
    logic [0:0]             s_axis_tuser = '0;   // [0] section_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [15:0] prog_num, [20:16] version, [21] current_next,
    // [29:22] section_index, [37:30] last_section_index, [50:38] clock_ref_pid,
    // [62:51] program_info_len, [70:63] es_type, [83:71] es_pid,
    // [95:84] es_info_len, [100:96] entry_count, [103:101] zero
    logic [pmt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [2:0]             m_axis_tuser;        // [2:0] kind

    pmt_section_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // bytes still to be offered and results the parser still owes
    t_sec_byte          byte_feed[$];
    pmt_pkg::t_result   due_results[$];
    logic        feed_calm = 1'b0;
    int unsigned bytes_queued = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned kind_seen[5] = '{default: 0};

    // parser model state
    pmt_pkg::t_phase  pm_phase = pmt_pkg::PH_IDLE;
    int unsigned pm_pos = 0;
    int unsigned pm_sec_len = 0;
    int unsigned pm_entry_at = 0;
    int unsigned pm_entries = 0;
    logic [7:0]  pm_hi = '0;
    pmt_pkg::t_result pm_hdr = '0;  // latched header, entry fields kept at zero
    logic [7:0]  pm_type = '0;
    logic [12:0] pm_pid = '0;
    logic [11:0] pm_es_len = '0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // hard stop in case the parser hangs or drops results
    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic clear_section();
        pm_pos = 0;
        pm_sec_len = 0;
        pm_entry_at = 0;
        pm_entries = 0;
        pm_hi = '0;
        pm_hdr = '0;
        pm_type = '0;
        pm_pid = '0;
        pm_es_len = '0;
    endtask

    task automatic push_result(input pmt_pkg::t_kind k, input bit with_entry);
        pmt_pkg::t_result r;
        r = pm_hdr;
        r.kind = k;
        if (with_entry) begin
            r.es_type = pm_type;
            r.es_pid = pm_pid;
            r.es_info_len = pm_es_len;
        end
        r.entry_count = pm_entries[pmt_pkg::ENTRY_CNT_W-1:0];
        due_results.push_back(r);
    endtask

    // advance the parser model by one accepted section byte
    task automatic parse_byte(input logic [7:0] b, input logic start);
        int unsigned next_at;
        if (start) begin
            // a start always opens a new section, even in the middle of one
            clear_section();
            if (b != pmt_pkg::PMT_TABLE_ID) begin
                pm_phase = pmt_pkg::PH_IDLE;
                push_result(pmt_pkg::KIND_BAD_TABLE, 1'b0);
            end else begin
                pm_phase = pmt_pkg::PH_HEADER;
            end
        end else if (pm_phase != pmt_pkg::PH_IDLE) begin
            pm_pos++;
            if (pm_phase == pmt_pkg::PH_HEADER) begin
                case (pm_pos)
                    1, 3, 8, 10: pm_hi = b;
                    2: pm_sec_len = 32'({pm_hi[3:0], b});
                    4: pm_hdr.prog_num = {pm_hi, b};
                    5: begin
                        pm_hdr.version = b[5:1];
                        pm_hdr.current_next = b[0];
                    end
                    6: pm_hdr.section_index = b;
                    7: pm_hdr.last_section_index = b;
                    9: pm_hdr.clock_ref_pid = {pm_hi[4:0], b};
                    default: begin
                        pm_hdr.program_info_len = {pm_hi[3:0], b};
                        push_result(pmt_pkg::KIND_HEADER, 1'b0);
                        // section may end right after the header
                        if (13 + pm_hdr.program_info_len >= pm_sec_len) begin
                            pm_phase = pmt_pkg::PH_IDLE;
                            push_result(pmt_pkg::KIND_DONE, 1'b0);
                        end else begin
                            pm_entry_at = 12 + pm_hdr.program_info_len;
                            pm_phase = pmt_pkg::PH_WAIT;
                        end
                    end
                endcase
            end else begin
                // skip descriptor bytes until the next entry begins
                if (pm_phase == pmt_pkg::PH_WAIT && pm_pos == pm_entry_at)
                    pm_phase = pmt_pkg::PH_ENTRY;
                if (pm_phase == pmt_pkg::PH_ENTRY) begin
                    case (pm_pos - pm_entry_at)
                        0: pm_type = b;
                        1, 3: pm_hi = b;
                        2: pm_pid = {pm_hi[4:0], b};
                        default: begin
                            pm_es_len = {pm_hi[3:0], b};
                            pm_entries++;
                            push_result(pmt_pkg::KIND_ENTRY, 1'b1);
                            next_at = pm_entry_at + 5 + pm_es_len;
                            // next entry inside the crc ends the section
                            if (next_at + 1 >= pm_sec_len) begin
                                pm_phase = pmt_pkg::PH_IDLE;
                                push_result(pmt_pkg::KIND_DONE, 1'b0);
                            end else if (pm_entries >= pmt_pkg::MAX_ENTRIES) begin
                                pm_phase = pmt_pkg::PH_IDLE;
                                push_result(pmt_pkg::KIND_FULL, 1'b0);
                            end else begin
                                pm_entry_at = next_at;
                                pm_phase = pmt_pkg::PH_WAIT;
                            end
                        end
                    endcase
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- driver
    t_sec_byte offer;
    int        src_wait = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            src_wait = 0;
        end else begin
            // model follows every byte transfer
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata, s_axis_tuser[0]);
                bytes_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (byte_feed.size() > 0) begin
                    offer = byte_feed.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= offer.data;
                    s_axis_tuser <= offer.start;
                    src_wait = offer.calm ? 0 : $urandom_range(0, 10);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // --------------------------------------------------------------- monitor
    pmt_pkg::t_result want;
    int      sink_wait = 0;
    int      long_holds = 0;
    logic    sink_calm = 1'b0;

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (m_axis_tuser < 5)
                    kind_seen[m_axis_tuser]++;
                if (due_results.size() == 0) begin
                    $error("result transfer with kind %0d but none expected", m_axis_tuser);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    check_field("kind", want.kind, m_axis_tuser);
                    check_field("prog_num", want.prog_num, m_axis_tdata[15:0]);
                    check_field("version", want.version, m_axis_tdata[20:16]);
                    check_field("current_next", want.current_next, m_axis_tdata[21]);
                    check_field("section_index", want.section_index, m_axis_tdata[29:22]);
                    check_field("last_section_index", want.last_section_index,
                                m_axis_tdata[37:30]);
                    check_field("clock_ref_pid", want.clock_ref_pid, m_axis_tdata[50:38]);
                    check_field("program_info_len", want.program_info_len,
                                m_axis_tdata[62:51]);
                    check_field("es_type", want.es_type, m_axis_tdata[70:63]);
                    check_field("es_pid", want.es_pid, m_axis_tdata[83:71]);
                    check_field("es_info_len", want.es_info_len, m_axis_tdata[95:84]);
                    check_field("entry_count", want.entry_count, m_axis_tdata[100:96]);
                end
                sink_wait = sink_calm ? 0 : $urandom_range(0, 10);
                // switch between stalling and free-running stretches
                if (results_seen % 48 == 0)
                    sink_calm = 1'($urandom_range(0, 1));
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            // long back-pressure so the result queue fills and the byte input stalls
            if (long_holds < 2 && results_seen >= (long_holds == 0 ? 40 : 150)) begin
                sink_wait = 400;
                long_holds++;
            end
            m_axis_tready <= (sink_wait == 0);
        end
    end

    // -------------------------------------------------------------- stimulus
    task automatic feed(input logic [7:0] b, input logic start);
        byte_feed.push_back('{data: b, start: start, calm: feed_calm});
        bytes_queued++;
    endtask

    // one program map section with random content, sometimes with a bad length or cut short
    task automatic build_section(input int n_ent, input int max_es, input int max_pil);
        int          pil;
        int          sec_len;
        int          base;
        int          es[$];
        logic [11:0] len12;
        pil = $urandom_range(0, max_pil);
        sec_len = 13 + pil;
        for (int i = 0; i < n_ent; i++) begin
            es.push_back($urandom_range(0, max_es));
            sec_len += 5 + es[i];
        end
        case ($urandom_range(0, 9))
            0: sec_len = $urandom_range(0, 4095);
            1: sec_len = sec_len - $urandom_range(1, 8);
            default: ;
        endcase
        len12 = 12'(sec_len);
        base = byte_feed.size();
        feed(pmt_pkg::PMT_TABLE_ID, 1'b1);
        feed({4'($urandom), len12[11:8]}, 1'b0);
        feed(len12[7:0], 1'b0);
        // program number, version byte, section numbers, pcr pid
        repeat (7) feed(8'($urandom), 1'b0);
        len12 = 12'(pil);
        feed({4'($urandom), len12[11:8]}, 1'b0);
        feed(len12[7:0], 1'b0);
        repeat (pil) feed(8'($urandom), 1'b0);
        foreach (es[i]) begin
            repeat (3) feed(8'($urandom), 1'b0);
            len12 = 12'(es[i]);
            feed({4'($urandom), len12[11:8]}, 1'b0);
            feed(len12[7:0], 1'b0);
            repeat (es[i]) feed(8'($urandom), 1'b0);
        end
        // crc bytes
        repeat (4) feed(8'($urandom), 1'b0);
        // cut short now and then so the next start abandons it
        if ($urandom_range(0, 9) == 0) begin
            sec_len = base + $urandom_range(1, byte_feed.size() - base - 1);
            while (byte_feed.size() > sec_len) begin
                void'(byte_feed.pop_back());
                bytes_queued--;
            end
        end
    endtask

    task automatic random_sections(input int unsigned upto);
        int n_ent;
        while (bytes_queued < upto) begin
            if ($urandom_range(0, 5) == 0)
                feed_calm = 1'($urandom_range(0, 1));
            n_ent = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 6);
            build_section(n_ent, ($urandom_range(0, 7) == 0) ? 60 : 6,
                          ($urandom_range(0, 7) == 0) ? 40 : 6);
            // stray bytes, ignored once the section is over
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) feed(8'($urandom), 1'b0);
            // start with a random table id, usually a wrong one
            if ($urandom_range(0, 7) == 0)
                feed(8'($urandom), 1'b1);
        end
    endtask

    // hold the sender until every byte went out and every result came back
    task automatic wait_quiet();
        while (byte_feed.size() > 0 || s_axis_tvalid || due_results.size() > 0)
            @(negedge i_clk);
    endtask

    initial begin
        @(negedge i_clk);
        feed_calm = 1'b1;
        // wrong table id
        feed(8'h00, 1'b1);
        // all-ones header: every field at its top value, descriptors run past the end
        feed(pmt_pkg::PMT_TABLE_ID, 1'b1);
        repeat (11) feed(8'hFF, 1'b0);
        // byte after section done is dropped
        feed(8'hA5, 1'b0);
        // all-zero header, one all-ones entry whose done shares its step
        feed(pmt_pkg::PMT_TABLE_ID, 1'b1);
        feed(8'h00, 1'b0);
        feed(8'd18, 1'b0);
        repeat (9) feed(8'h00, 1'b0);
        repeat (5) feed(8'hFF, 1'b0);
        // header cut off by the next start
        feed(pmt_pkg::PMT_TABLE_ID, 1'b1);
        repeat (3) feed(8'($urandom), 1'b0);
        wait_quiet();

        // first random section has enough entries to fill the entry table
        feed_calm = 1'b0;
        build_section(17, 4, 4);
        random_sections(700);
        wait_quiet();
        random_sections(1450);
        wait_quiet();
        repeat (10) @(negedge i_clk);

        $display("sent %0d section bytes, checked %0d results", bytes_sent, results_seen);
        $display("headers %0d, entries %0d, done %0d, wrong table %0d, table full %0d",
                 kind_seen[pmt_pkg::KIND_HEADER], kind_seen[pmt_pkg::KIND_ENTRY],
                 kind_seen[pmt_pkg::KIND_DONE], kind_seen[pmt_pkg::KIND_BAD_TABLE],
                 kind_seen[pmt_pkg::KIND_FULL]);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
